FILE: hw/rtl/timer_uart_8n1_assert.svh
// Assertion macros used by the timer_uart_8n1 top level.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef TIMER_UART_8N1_ASSERT_SVH
`define TIMER_UART_8N1_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define TMU_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("timer_uart_8n1 assertion failed");

// Next-cycle implication, disabled while in reset.
`define TMU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("timer_uart_8n1 assertion failed");

`endif

FILE: hw/rtl/tmu_pkg.sv
// Package for timer_uart_8n1: sizes, beat payload types and result groups.
// No dependencies; timer_uart_8n1, tmu_tx and tmu_rx import it.
`default_nettype none

package tmu_pkg;

    localparam int TIMER_WIDTH    = 16;
    localparam int DATA_BITS      = 8;
    localparam int FRAME_BITS     = DATA_BITS + 2;
    localparam int RX_TIMER_WIDTH = 17;
    localparam int PERIOD_WIDTH   = 16;
    localparam int TX_CNT_WIDTH   = $clog2(FRAME_BITS + 1);
    localparam int RX_CNT_WIDTH   = $clog2(DATA_BITS + 1);

    localparam logic [PERIOD_WIDTH-1:0] BIT_PERIOD_RESET = 16'd104;

    typedef struct packed {
        logic       rx_line;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       tx_last;
    } in_t;

    typedef struct packed {
        logic       tx_line;
        logic       tx_take;
        logic       tx_busy;
        logic       tx_done;
        logic       rx_valid;
        logic [7:0] rx_byte;
    } out_t;

    typedef struct packed {
        logic tx_line;
        logic tx_take;
        logic tx_busy;
        logic tx_done;
    } tx_res_t;

    typedef struct packed {
        logic       rx_valid;
        logic [7:0] rx_byte;
    } rx_res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/timer_uart_8n1.sv
// Top level of timer_uart_8n1: configuration register, both UART halves, result register.
// Depends on tmu_pkg, tmu_tx, tmu_rx and timer_uart_8n1_assert.svh.
`default_nettype none

// Full-duplex 8N1 UART in which every input beat is one tick of the bit timer.
// One input beat is taken per cycle while in_ready is high, and gives exactly
// one result beat, which appears in the output register on the cycle after
// acceptance. The single output register sets the rate: in_ready is low only
// while that register holds a result that out_ready does not take in the same
// cycle, so with the output side always ready the block runs at one beat per
// cycle. The bit_period register is written through the cfg channel, which is
// always ready; a new value is used from the next bit timer reload onwards.
module timer_uart_8n1
    import tmu_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [PERIOD_WIDTH-1:0] cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire in_t                     in_data,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output out_t                         out_data
);

    logic [PERIOD_WIDTH-1:0] bit_period_reg;
    logic                    out_valid_reg;
    out_t                    out_data_reg, out_data_next;
    logic                    step;
    tx_res_t                 tx_res;
    rx_res_t                 rx_res;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign step      = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_period_reg <= BIT_PERIOD_RESET;
        end
        else if (cfg_valid)
        begin
            bit_period_reg <= cfg_data;
        end
    end

    tmu_tx u_tx (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .bit_period (bit_period_reg),
        .tx_valid   (in_data.tx_valid),
        .tx_byte    (in_data.tx_byte),
        .tx_last    (in_data.tx_last),
        .res        (tx_res)
    );

    tmu_rx u_rx (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .bit_period (bit_period_reg),
        .rx_line    (in_data.rx_line),
        .res        (rx_res)
    );

    always_comb
    begin
        out_data_next.tx_line  = tx_res.tx_line;
        out_data_next.tx_take  = tx_res.tx_take;
        out_data_next.tx_busy  = tx_res.tx_busy;
        out_data_next.tx_done  = tx_res.tx_done;
        out_data_next.rx_valid = rx_res.rx_valid;
        out_data_next.rx_byte  = rx_res.rx_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_data_reg <= out_data_next;
        end
    end

`include "timer_uart_8n1_assert.svh"

    `TMU_ASSERT_NEXT(a_step_fills_out, step, out_valid_reg)
    `TMU_ASSERT_IMPL(a_take_busy, out_valid_reg && out_data_reg.tx_take, out_data_reg.tx_busy)
    `TMU_ASSERT_IMPL(a_done_idle, out_valid_reg && out_data_reg.tx_done,
        !out_data_reg.tx_busy && !out_data_reg.tx_take && out_data_reg.tx_line)
    `TMU_ASSERT_IMPL(a_rx_byte_zero, out_valid_reg && !out_data_reg.rx_valid,
        out_data_reg.rx_byte == 8'd0)

endmodule

`default_nettype wire

FILE: hw/rtl/tmu_tx.sv
// Transmit half of timer_uart_8n1: frame shifter, bit timer and buffer sequencing.
// Depends on tmu_pkg.
`default_nettype none

module tmu_tx
    import tmu_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    step,
    input  wire logic [PERIOD_WIDTH-1:0] bit_period,
    input  wire logic                    tx_valid,
    input  wire logic [7:0]              tx_byte,
    input  wire logic                    tx_last,
    output tx_res_t                      res
);

    logic [TIMER_WIDTH-1:0]  timer_reg, timer_next;
    logic [FRAME_BITS-1:0]   shift_reg, shift_next;
    logic [TX_CNT_WIDTH-1:0] bits_reg, bits_next;
    logic                    active_reg, active_next;
    logic                    final_reg, final_next;

    logic [31:0]             period_ext;
    logic [TIMER_WIDTH-1:0]  reload;
    logic [DATA_BITS+7:0]    byte_ext;
    logic [DATA_BITS-1:0]    data;
    logic                    load;

    assign period_ext = 32'(bit_period);
    assign reload     = period_ext[TIMER_WIDTH-1:0];
    assign byte_ext   = {{DATA_BITS{1'b0}}, tx_byte};
    assign data       = byte_ext[DATA_BITS-1:0];

    always_comb
    begin
        timer_next  = timer_reg;
        shift_next  = shift_reg;
        bits_next   = bits_reg;
        active_next = active_reg;
        final_next  = final_reg;
        res         = '0;
        load        = 1'b0;

        if (active_reg)
        begin
            if (bits_reg != '0)
            begin
                if (timer_reg > TIMER_WIDTH'(1))
                begin
                    timer_next = timer_reg - TIMER_WIDTH'(1);
                end
                else
                begin
                    shift_next = shift_reg >> 1;
                    bits_next  = bits_reg - TX_CNT_WIDTH'(1);
                    timer_next = reload;
                    if ((bits_next == '0) && final_reg)
                    begin
                        active_next = 1'b0;
                        final_next  = 1'b0;
                        shift_next  = '1;
                        bits_next   = TX_CNT_WIDTH'(FRAME_BITS);
                        res.tx_done = 1'b1;
                    end
                end
            end
            // A non-final frame that has ended fetches the next byte here.
            if (active_next && (bits_next == '0) && tx_valid)
            begin
                load = 1'b1;
            end
        end
        else if (tx_valid)
        begin
            load = 1'b1;
        end

        if (load)
        begin
            shift_next  = {1'b1, data, 1'b0};
            bits_next   = TX_CNT_WIDTH'(FRAME_BITS);
            timer_next  = reload;
            active_next = 1'b1;
            final_next  = tx_last;
        end

        res.tx_take = load;
        res.tx_busy = active_next;
        res.tx_line = (active_next && (bits_next != '0)) ? shift_next[0] : 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg  <= '0;
            shift_reg  <= '1;
            bits_reg   <= TX_CNT_WIDTH'(FRAME_BITS);
            active_reg <= 1'b0;
            final_reg  <= 1'b0;
        end
        else if (step)
        begin
            timer_reg  <= timer_next;
            shift_reg  <= shift_next;
            bits_reg   <= bits_next;
            active_reg <= active_next;
            final_reg  <= final_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tmu_rx.sv
// Receive half of timer_uart_8n1: start edge hunt, sample timer and shifter.
// Depends on tmu_pkg.
`default_nettype none

module tmu_rx
    import tmu_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    step,
    input  wire logic [PERIOD_WIDTH-1:0] bit_period,
    input  wire logic                    rx_line,
    output rx_res_t                      res
);

    logic [RX_TIMER_WIDTH-1:0] timer_reg, timer_next;
    logic [DATA_BITS-1:0]      shift_reg, shift_next;
    logic [RX_CNT_WIDTH-1:0]   bits_reg, bits_next;
    logic                      sampling_reg, sampling_next;
    logic                      prev_reg;

    logic [RX_TIMER_WIDTH-1:0] reload;
    logic [RX_TIMER_WIDTH-1:0] start_wait;
    logic [DATA_BITS+7:0]      shift_ext;

    assign reload     = RX_TIMER_WIDTH'(bit_period);
    // The first sample lands in the middle of data bit zero.
    assign start_wait = reload + RX_TIMER_WIDTH'(bit_period >> 1);
    assign shift_ext  = {8'd0, shift_next};

    always_comb
    begin
        timer_next    = timer_reg;
        shift_next    = shift_reg;
        bits_next     = bits_reg;
        sampling_next = sampling_reg;
        res           = '0;

        if (sampling_reg)
        begin
            if (timer_reg > RX_TIMER_WIDTH'(1))
            begin
                timer_next = timer_reg - RX_TIMER_WIDTH'(1);
            end
            else
            begin
                shift_next = {rx_line, shift_reg[DATA_BITS-1:1]};
                if (bits_reg != '0)
                begin
                    bits_next = bits_reg - RX_CNT_WIDTH'(1);
                end
                timer_next = reload;
                if (bits_next == '0)
                begin
                    res.rx_valid  = 1'b1;
                    res.rx_byte   = shift_ext[7:0];
                    bits_next     = RX_CNT_WIDTH'(DATA_BITS);
                    sampling_next = 1'b0;
                end
            end
        end
        else if (prev_reg && !rx_line)
        begin
            sampling_next = 1'b1;
            timer_next    = start_wait;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg    <= '0;
            shift_reg    <= '0;
            bits_reg     <= RX_CNT_WIDTH'(DATA_BITS);
            sampling_reg <= 1'b0;
            prev_reg     <= 1'b1;
        end
        else if (step)
        begin
            timer_reg    <= timer_next;
            shift_reg    <= shift_next;
            bits_reg     <= bits_next;
            sampling_reg <= sampling_next;
            prev_reg     <= rx_line;
        end
    end

endmodule

`default_nettype wire
